/* rtl/core/aspfp_pkg.sv */
`default_nettype none

package aspfp_pkg;

    // Result queue between the byte classifier and the output stage
    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W  = 8;
    localparam int ID_W    = 4;
    localparam int VALUE_W = 10;
    localparam int POS_W   = 6;
    localparam int SUM_W   = 12;

    // Characters of the stream
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;

    // Packet positions
    localparam logic [POS_W-1:0] POS_ADDR     = 6'd1;
    localparam logic [POS_W-1:0] POS_SUM_LAST = 6'd44;
    localparam logic [POS_W-1:0] POS_LAST     = 6'd48;

    // Checksum adds (byte - '0'), i.e. byte + (4096 - 48) modulo 4096
    localparam logic [SUM_W-1:0] SUM_BIAS = 12'd4048;

    // Result identifiers
    localparam logic [ID_W-1:0] ID_STATUS = 4'd0;
    localparam logic [ID_W-1:0] ID_TYPE   = 4'd1;
    localparam logic [ID_W-1:0] ID_UNIT   = 4'd2;
    localparam logic [ID_W-1:0] ID_CHECK  = 4'd15;

    // Status and type codes
    localparam logic [VALUE_W-1:0] ST_OK       = 10'd0;
    localparam logic [VALUE_W-1:0] ST_BAD_ADDR = 10'd1;
    localparam logic [VALUE_W-1:0] ST_BAD_SUM  = 10'd2;
    localparam logic [VALUE_W-1:0] TYPE_INV    = 10'd0;
    localparam logic [VALUE_W-1:0] TYPE_CHG    = 10'd1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] value;
        logic               last;
    } result_t;

    // One queue entry carries the one or two results of a byte
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic            hit;
        logic            is_first;
        logic            is_end;
        logic [ID_W-1:0] id;
    } field_pos_t;

    // Map a packet position to the decimal field that covers it
    function automatic field_pos_t field_lookup(input logic [POS_W-1:0] pos);
        field_pos_t f;
        f = '0;
        unique case (pos)
            6'd3:  f = '{1'b1, 1'b1, 1'b0, 4'd3};
            6'd4:  f = '{1'b1, 1'b0, 1'b1, 4'd3};
            6'd6:  f = '{1'b1, 1'b1, 1'b0, 4'd4};
            6'd7:  f = '{1'b1, 1'b0, 1'b1, 4'd4};
            6'd9:  f = '{1'b1, 1'b1, 1'b0, 4'd5};
            6'd10: f = '{1'b1, 1'b0, 1'b1, 4'd5};
            6'd13: f = '{1'b1, 1'b1, 1'b0, 4'd6};
            6'd14: f = '{1'b1, 1'b0, 1'b0, 4'd6};
            6'd15: f = '{1'b1, 1'b0, 1'b1, 4'd6};
            6'd16: f = '{1'b1, 1'b1, 1'b0, 4'd7};
            6'd17: f = '{1'b1, 1'b0, 1'b0, 4'd7};
            6'd18: f = '{1'b1, 1'b0, 1'b1, 4'd7};
            6'd20: f = '{1'b1, 1'b1, 1'b0, 4'd8};
            6'd21: f = '{1'b1, 1'b0, 1'b1, 4'd8};
            6'd23: f = '{1'b1, 1'b1, 1'b0, 4'd9};
            6'd24: f = '{1'b1, 1'b0, 1'b1, 4'd9};
            6'd26: f = '{1'b1, 1'b1, 1'b0, 4'd10};
            6'd27: f = '{1'b1, 1'b0, 1'b0, 4'd10};
            6'd28: f = '{1'b1, 1'b0, 1'b1, 4'd10};
            6'd30: f = '{1'b1, 1'b1, 1'b0, 4'd11};
            6'd31: f = '{1'b1, 1'b0, 1'b1, 4'd11};
            6'd33: f = '{1'b1, 1'b1, 1'b0, 4'd12};
            6'd34: f = '{1'b1, 1'b0, 1'b0, 4'd12};
            6'd35: f = '{1'b1, 1'b0, 1'b1, 4'd12};
            6'd37: f = '{1'b1, 1'b1, 1'b0, 4'd13};
            6'd38: f = '{1'b1, 1'b0, 1'b0, 4'd13};
            6'd39: f = '{1'b1, 1'b0, 1'b1, 4'd13};
            6'd41: f = '{1'b1, 1'b1, 1'b0, 4'd14};
            6'd42: f = '{1'b1, 1'b0, 1'b0, 4'd14};
            6'd43: f = '{1'b1, 1'b0, 1'b1, 4'd14};
            6'd45: f = '{1'b1, 1'b1, 1'b0, ID_CHECK};
            6'd46: f = '{1'b1, 1'b0, 1'b0, ID_CHECK};
            6'd47: f = '{1'b1, 1'b0, 1'b1, ID_CHECK};
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/aspfp_byte_if.sv */
`default_nettype none

interface aspfp_byte_if;
    logic                           valid;
    logic                           ready;
    logic [aspfp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/aspfp_result_if.sv */
`default_nettype none

interface aspfp_result_if;
    logic                           valid;
    logic                           ready;
    logic [aspfp_pkg::ID_W-1:0]     field_id;
    logic [aspfp_pkg::VALUE_W-1:0]  field_value;
    logic                           last;

    modport source (output valid, output field_id, output field_value, output last,
                    input ready);
    modport sink   (input valid, input field_id, input field_value, input last,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/ascii_status_packet_field_parser.sv */
`default_nettype none

// ASCII status packet field parser.
// rx carries one received byte per beat; result carries one decoded field
// per beat (field_id, field_value, last). A line feed opens a 49-byte
// packet; the address byte yields a type and a unit beat, each fixed
// decimal field yields one beat when its last digit arrives, and position
// 48 yields a status beat with last set (0 ok, 2 checksum mismatch). A bad
// address yields status 1 with last set and drops the rest of the packet.
// Throughput: one byte per cycle on rx while the queue has space; the
// result side drains one beat per cycle while result.ready is high, and an
// address byte yields two beats. A byte's results are written to the front
// queue on the accepting edge and then loaded into the output register once
// it is empty or its entry's final beat goes out.
// The front classifier keeps accepting while the output is stalled, until
// the Q_DEPTH-entry queue fills; rx.ready then drops until space frees.
// Reset: rst_n clears the frame state (waiting for a line feed), empties
// the queue and the output register. No clearing pass is needed.
module ascii_status_packet_field_parser #(
    parameter int Q_DEPTH = aspfp_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    aspfp_byte_if.sink      rx,
    aspfp_result_if.source  result
);
    import aspfp_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    entry_t q_wr_entry;
    entry_t q_rd_entry;

    // Classify bytes, track packet position, checksum and field digits
    aspfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_wr_entry)
    );

    // Hold pending result groups between the two sides
    aspfp_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_wr_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_rd_entry),
        .not_empty  (q_valid)
    );

    // Serialize each group into result beats through an output register
    aspfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_rd_entry),
        .q_pop   (q_pop),
        .result  (result)
    );

    // The front never writes a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("result queue overflow");

    // The back never pulls from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("result queue underflow");

    // Exactly the status beat closes a packet
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.field_id == ID_STATUS) == result.last))
        else $error("last flag does not match status beat");

    // Type beat always carries inverter or charger
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.field_id == ID_TYPE)) |->
        ((result.field_value == TYPE_INV) || (result.field_value == TYPE_CHG)))
        else $error("type beat out of range");

endmodule

`default_nettype wire

/* rtl/core/aspfp_front.sv */
`default_nettype none

module aspfp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    aspfp_byte_if.sink             rx,
    input  wire logic              q_full,
    output logic                   q_push,
    output aspfp_pkg::entry_t      q_entry
);
    import aspfp_pkg::*;

    logic               in_frame_reg, in_frame_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [VALUE_W-1:0] field_accum_reg, field_accum_next;
    logic               field_stopped_reg, field_stopped_next;
    logic [SUM_W-1:0]   sum_accum_reg, sum_accum_next;
    logic [VALUE_W-1:0] check_value_reg, check_value_next;

    logic               accept;
    logic [BYTE_W-1:0]  b;
    logic               digit;
    logic               letter;
    logic [3:0]         dval;
    logic [POS_W-1:0]   pos;
    field_pos_t         fp;
    logic [VALUE_W-1:0] acc_step;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign digit    = (b >= CH_ZERO) && (b <= CH_NINE);
    assign letter   = (b >= CH_A) && (b <= CH_K);
    assign dval     = digit ? 4'(b - CH_ZERO) : 4'(b - CH_A);
    assign pos      = position_reg + 1'b1;
    assign fp       = field_lookup(pos);
    // accum * 10 + digit, wrapping at the field width
    assign acc_step = {field_accum_reg[VALUE_W-4:0], 3'b000}
                    + {field_accum_reg[VALUE_W-2:0], 1'b0}
                    + VALUE_W'(dval);

    always_comb
    begin
        in_frame_next      = in_frame_reg;
        position_next      = position_reg;
        field_accum_next   = field_accum_reg;
        field_stopped_next = field_stopped_reg;
        sum_accum_next     = sum_accum_reg;
        check_value_next   = check_value_reg;
        q_push             = 1'b0;
        q_entry            = '0;

        if (accept)
        begin
            if (b == CH_LF)
            begin
                // resynchronize: open a fresh packet
                in_frame_next      = 1'b1;
                position_next      = '0;
                field_accum_next   = '0;
                field_stopped_next = 1'b0;
                sum_accum_next     = '0;
                check_value_next   = '0;
            end
            else if (in_frame_reg)
            begin
                position_next = pos;
                if ((pos <= POS_SUM_LAST) && (b != CH_COMMA) && (b != CH_STAR))
                begin
                    sum_accum_next = sum_accum_reg + SUM_W'(b) + SUM_BIAS;
                end

                priority if (pos == POS_ADDR)
                begin
                    q_push = 1'b1;
                    if (digit || letter)
                    begin
                        q_entry.two      = 1'b1;
                        q_entry.r0.id    = ID_TYPE;
                        q_entry.r0.value = digit ? TYPE_INV : TYPE_CHG;
                        q_entry.r0.last  = 1'b0;
                        q_entry.r1.id    = ID_UNIT;
                        q_entry.r1.value = VALUE_W'(dval);
                        q_entry.r1.last  = 1'b0;
                    end
                    else
                    begin
                        // bad address: close the packet, drop the rest
                        q_entry.r0.id    = ID_STATUS;
                        q_entry.r0.value = ST_BAD_ADDR;
                        q_entry.r0.last  = 1'b1;
                        in_frame_next    = 1'b0;
                    end
                end
                else if (pos >= POS_LAST)
                begin
                    q_push           = 1'b1;
                    q_entry.r0.id    = ID_STATUS;
                    q_entry.r0.value = (sum_accum_reg == SUM_W'(check_value_reg))
                                       ? ST_OK : ST_BAD_SUM;
                    q_entry.r0.last  = 1'b1;
                    in_frame_next    = 1'b0;
                end
                else if (fp.hit)
                begin
                    priority if (fp.is_first)
                    begin
                        field_accum_next   = digit ? VALUE_W'(dval) : '0;
                        field_stopped_next = !digit;
                    end
                    else if (!field_stopped_reg && digit)
                    begin
                        field_accum_next = acc_step;
                    end
                    else
                    begin
                        field_stopped_next = 1'b1;
                    end

                    if (fp.is_end)
                    begin
                        if (fp.id == ID_CHECK)
                        begin
                            check_value_next = field_accum_next;
                        end
                        q_push           = 1'b1;
                        q_entry.r0.id    = fp.id;
                        q_entry.r0.value = field_accum_next;
                        q_entry.r0.last  = 1'b0;
                    end
                end
                else
                begin
                    // separator byte: no result
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg      <= 1'b0;
            position_reg      <= '0;
            field_accum_reg   <= '0;
            field_stopped_reg <= 1'b0;
            sum_accum_reg     <= '0;
            check_value_reg   <= '0;
        end
        else
        begin
            in_frame_reg      <= in_frame_next;
            position_reg      <= position_next;
            field_accum_reg   <= field_accum_next;
            field_stopped_reg <= field_stopped_next;
            sum_accum_reg     <= sum_accum_next;
            check_value_reg   <= check_value_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aspfp_fifo.sv */
`default_nettype none

module aspfp_fifo #(
    parameter int DEPTH = aspfp_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire aspfp_pkg::entry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output aspfp_pkg::entry_t       pop_entry,
    output logic                    not_empty
);
    import aspfp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aspfp_back.sv */
`default_nettype none

module aspfp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire aspfp_pkg::entry_t  q_entry,
    output logic                    q_pop,
    aspfp_result_if.source          result
);
    import aspfp_pkg::*;

    logic       have_reg, have_next;
    logic       second_reg, second_next;
    entry_t     entry_reg, entry_next;
    result_t    cur;
    logic       fire;
    logic       done;

    assign cur                = second_reg ? entry_reg.r1 : entry_reg.r0;
    assign result.valid       = have_reg;
    assign result.field_id    = cur.id;
    assign result.field_value = cur.value;
    assign result.last        = cur.last;

    assign fire  = have_reg && result.ready;
    // entry finished once its final result beat goes out
    assign done  = fire && (second_reg || !entry_reg.two);
    assign q_pop = q_valid && (!have_reg || done);

    always_comb
    begin
        have_next   = have_reg;
        second_next = second_reg;
        entry_next  = entry_reg;
        if (q_pop)
        begin
            have_next   = 1'b1;
            second_next = 1'b0;
            entry_next  = q_entry;
        end
        else if (done)
        begin
            have_next   = 1'b0;
            second_next = 1'b0;
        end
        else if (fire)
        begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            have_reg   <= have_next;
            second_reg <= second_next;
        end
    end

endmodule

`default_nettype wire

/* sim/status_field_checker.sv */
module status_field_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rx_valid,
    input  logic                         rx_ready,
    input  logic [aspfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  logic [aspfp_pkg::ID_W-1:0]   field_id,
    input  logic [aspfp_pkg::VALUE_W-1:0] field_value,
    input  logic                         last,
    output int                           mismatch_count,
    output int                           fields_pending
);
    import aspfp_pkg::*;

    localparam int NUM_FIELDS = 13;
    localparam int FIELD_FIRST [NUM_FIELDS] = '{3, 6, 9, 13, 16, 20, 23, 26, 30, 33, 37, 41, 45};
    localparam int FIELD_LEN [NUM_FIELDS]   = '{2, 2, 2, 3, 3, 2, 2, 3, 2, 3, 3, 3, 3};
    // field k reports as id k+3, so the checksum field lands on ID_CHECK
    localparam int FIRST_FIELD_ID = 3;
    localparam int CHECK_FIELD    = NUM_FIELDS - 1;
    localparam int MAX_PRINTED    = 40;

    logic               frame_open;
    logic [POS_W-1:0]   frame_pos;
    logic [VALUE_W-1:0] digit_acc;
    logic               digits_done;
    logic [SUM_W-1:0]   running_sum;
    logic [VALUE_W-1:0] sent_sum;
    result_t            expected_fields [$];
    int                 beat_no;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at result beat %0d: %s", beat_no, what);
    endtask

    task automatic expect_field(input logic [ID_W-1:0] id, input logic [VALUE_W-1:0] value,
                                input logic is_last);
        result_t r;
        r.id    = id;
        r.value = value;
        r.last  = is_last;
        expected_fields.push_back(r);
    endtask

    task automatic restart_frame();
        frame_pos   = '0;
        digit_acc   = '0;
        digits_done = 1'b0;
        running_sum = '0;
        sent_sum    = '0;
    endtask

    // advance the parser by one byte and queue the fields it completes
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic             dig;
        logic [POS_W-1:0] p;
        int               k;
        int               stop;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        if (b == CH_LF) begin
            frame_open = 1'b1;
            restart_frame();
        end else if (frame_open) begin
            p = frame_pos + 1'b1;
            frame_pos = p;
            if (p <= POS_SUM_LAST && b != CH_COMMA && b != CH_STAR)
                running_sum = running_sum + b + SUM_BIAS;
            if (p == POS_ADDR) begin
                if (dig) begin
                    expect_field(ID_TYPE, TYPE_INV, 1'b0);
                    expect_field(ID_UNIT, VALUE_W'(b - CH_ZERO), 1'b0);
                end else if (b >= CH_A && b <= CH_K) begin
                    expect_field(ID_TYPE, TYPE_CHG, 1'b0);
                    expect_field(ID_UNIT, VALUE_W'(b - CH_A), 1'b0);
                end else begin
                    expect_field(ID_STATUS, ST_BAD_ADDR, 1'b1);
                    frame_open = 1'b0;
                end
            end else if (p >= POS_LAST) begin
                expect_field(ID_STATUS, (running_sum == sent_sum) ? ST_OK : ST_BAD_SUM, 1'b1);
                frame_open = 1'b0;
            end else begin
                for (k = 0; k < NUM_FIELDS; k++) begin
                    stop = FIELD_FIRST[k] + FIELD_LEN[k] - 1;
                    if (p >= FIELD_FIRST[k] && p <= stop) begin
                        if (p == FIELD_FIRST[k]) begin
                            digit_acc   = dig ? VALUE_W'(b - CH_ZERO) : '0;
                            digits_done = !dig;
                        end else if (!digits_done && dig) begin
                            digit_acc = VALUE_W'(digit_acc * 10 + (b - CH_ZERO));
                        end else begin
                            digits_done = 1'b1;
                        end
                        if (p == stop) begin
                            if (k == CHECK_FIELD)
                                sent_sum = digit_acc;
                            expect_field(ID_W'(FIRST_FIELD_ID + k), digit_acc, 1'b0);
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            frame_open = 1'b0;
            restart_frame();
            expected_fields.delete();
            beat_no = 0;
            fields_pending <= 0;
        end else begin
            // queue before compare so a same-edge result would still find its entry
            if (rx_valid && rx_ready)
                decode_byte(rx_byte);
            if (result_valid && result_ready) begin
                if (expected_fields.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat id %0d value %0d last %0b",
                                              field_id, field_value, last));
                end else begin
                    want = expected_fields.pop_front();
                    if (field_id !== want.id)
                        report_mismatch($sformatf("field_id %0d, expected %0d",
                                                  field_id, want.id));
                    if (field_value !== want.value)
                        report_mismatch($sformatf("field_value %0d, expected %0d (id %0d)",
                                                  field_value, want.value, want.id));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b (id %0d)",
                                                  last, want.last, want.id));
                end
                beat_no++;
            end
            fields_pending <= expected_fields.size();
        end
    end

endmodule

/* sim/testbench.sv */
module testbench;
    import aspfp_pkg::*;

    // Stimulus stops once this many framed bytes have gone in; noise is not counted.
    localparam int FRAME_ITEMS     = 1750;
    // Longest correct quiet stretch is the receiver hold-off plus a few gaps.
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int FRAME_LEN       = 49;
    localparam int NUM_FIELDS      = 13;
    localparam int CHECK_FIELD     = NUM_FIELDS - 1;
    localparam int FIELD_FIRST [NUM_FIELDS] = '{3, 6, 9, 13, 16, 20, 23, 26, 30, 33, 37, 41, 45};
    localparam int FIELD_LEN [NUM_FIELDS]   = '{2, 2, 2, 3, 3, 2, 2, 3, 2, 3, 3, 3, 3};
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_ADDR, FRAME_CUT} frame_kind_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_MAX} frame_fill_t;

    logic clk;
    logic rst_n;

    aspfp_byte_if   rx_if ();
    aspfp_result_if res_if ();

    int mismatch_count;
    int fields_pending;
    int idle_cycles;
    int frame_items;
    bit tx_fast;
    bit rx_fast;
    bit hold_off_req;

    logic [BYTE_W-1:0] frame_buf [0:FRAME_LEN-1];

    ascii_status_packet_field_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .result (res_if)
    );

    // The checker only watches both channels; it never drives the handshake.
    status_field_checker field_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_if.valid),
        .rx_ready       (rx_if.ready),
        .rx_byte        (rx_if.rx_byte),
        .result_valid   (res_if.valid),
        .result_ready   (res_if.ready),
        .field_id       (res_if.field_id),
        .field_value    (res_if.field_value),
        .last           (res_if.last),
        .mismatch_count (mismatch_count),
        .fields_pending (fields_pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Any byte that is not a digit and not a line feed: used for separators,
    // the closing byte and broken field content.
    function automatic logic [BYTE_W-1:0] filler_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_LF);
        return b;
    endfunction

    // Write a zero-padded decimal number into the frame buffer.
    function automatic void put_decimal(input int first, input int len, input int value);
        int j;
        int v;
        v = value;
        for (j = len - 1; j >= 0; j--) begin
            frame_buf[first + j] = CH_ZERO + BYTE_W'(v % 10);
            v = v / 10;
        end
    endfunction

    // Offer one beat after a random gap and hold it until it is taken.
    // valid is only lowered when a gap follows, so a back-to-back beat keeps
    // valid high without a second assignment in the same step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
    endtask

    // Stop offering and wait until every queued field has come out.
    // fields_pending is updated with a nonblocking write on the edge that
    // accepts a byte, so after that edge it already counts that byte's fields.
    task automatic drain_fields();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (fields_pending != 0)
            @(posedge clk);
    endtask

    // Build one frame: line feed, address, the fixed decimal fields with
    // separators between them, the checksum and the closing byte.
    task automatic send_frame(input frame_kind_t kind, input frame_fill_t fill);
        logic [BYTE_W-1:0] addr;
        logic [SUM_W-1:0]  sum;
        int                p;
        int                k;
        int                r;
        int                lim;
        int                value;
        int                n;
        frame_buf[0] = CH_LF;
        if (kind == FRAME_BAD_ADDR) begin
            do
                addr = BYTE_W'($urandom_range(0, 255));
            while ((addr >= CH_ZERO && addr <= CH_NINE) || (addr >= CH_A && addr <= CH_K) ||
                   addr == CH_LF);
        end else if ($urandom_range(0, 1) == 0) begin
            addr = CH_ZERO + BYTE_W'($urandom_range(0, 9));
        end else begin
            addr = CH_A + BYTE_W'($urandom_range(0, 10));
        end
        frame_buf[1] = addr;
        for (p = 2; p < FRAME_LEN; p++) begin
            r = $urandom_range(0, 99);
            frame_buf[p] = (r < 85) ? CH_COMMA : (r < 90) ? CH_STAR : filler_byte();
        end
        frame_buf[FRAME_LEN - 1] = ($urandom_range(0, 3) == 0) ? filler_byte() : CH_CR;
        for (k = 0; k < NUM_FIELDS; k++) begin
            lim = (FIELD_LEN[k] == 2) ? 99 : 999;
            r   = $urandom_range(0, 9);
            if (fill == FILL_ZERO)
                value = 0;
            else if (fill == FILL_MAX || r == 1)
                value = lim;
            else if (r == 0)
                value = 0;
            else
                value = $urandom_range(0, lim);
            put_decimal(FIELD_FIRST[k], FIELD_LEN[k], value);
            // break a field now and then so accumulation stops early
            if (fill == FILL_RANDOM && $urandom_range(0, 11) == 0)
                frame_buf[FIELD_FIRST[k] + $urandom_range(0, FIELD_LEN[k] - 1)] = filler_byte();
        end
        sum = '0;
        for (p = 1; p <= POS_SUM_LAST; p++)
            if (frame_buf[p] != CH_COMMA && frame_buf[p] != CH_STAR)
                sum = sum + frame_buf[p] + SUM_BIAS;
        if (kind == FRAME_BAD_SUM)
            put_decimal(FIELD_FIRST[CHECK_FIELD], 3,
                        int'((sum + $urandom_range(1, 999)) % 1000));
        else if (sum <= 999)
            put_decimal(FIELD_FIRST[CHECK_FIELD], 3, int'(sum));
        // a bad address drops the rest, so only a short tail follows it;
        // a cut frame is restarted by the next frame's line feed
        if (kind == FRAME_BAD_ADDR)
            n = 2 + $urandom_range(0, 8);
        else if (kind == FRAME_CUT)
            n = $urandom_range(2, FRAME_LEN - 2);
        else
            n = FRAME_LEN;
        for (p = 0; p < n; p++)
            send_byte(frame_buf[p]);
        frame_items += (kind == FRAME_BAD_ADDR) ? 2 : n;
    endtask

    // Receiver: random stall before every beat, runs with no stall at all,
    // and one long hold-off on request so the block backs up into rx.
    initial begin
        int stall;
        int beats;
        res_if.ready <= 1'b0;
        beats = 0;
        rx_fast = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (beats % 64 == 0)
                rx_fast = ($urandom_range(0, 3) == 0);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = rx_fast ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_if.valid);
            beats++;
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] opening [0:23];
        int                i;
        int                r;
        int                frame_no;
        int                noise;
        frame_kind_t       kind;

        rst_n = 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        idle_cycles  = 0;
        frame_items  = 0;
        tx_fast      = 1'b0;
        hold_off_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening:
        //   idle bytes with no frame open, including all-zero and all-one bytes;
        //   addresses just outside the digit and letter ranges (bad address),
        //   with a byte after one that must be ignored;
        //   a line feed inside a frame that restarts it;
        //   a charger address, a full two-digit field and a field whose first
        //   byte is not a digit; an inverter address at unit zero.
        opening = '{8'h00, 8'hFF, CH_A,
                    CH_LF, CH_ZERO - 8'd1, 8'h78,
                    CH_LF, CH_NINE + 8'd1,
                    CH_LF, CH_A - 8'd1,
                    CH_LF, CH_K + 8'd1,
                    CH_LF, CH_NINE, CH_LF, CH_K, CH_COMMA, CH_NINE, CH_NINE,
                    CH_COMMA, 8'h2D, CH_ZERO + 8'd5,
                    CH_LF, CH_ZERO};
        for (i = 0; i < 24; i++)
            send_byte(opening[i]);

        // Random frames: mostly well formed with random content, the rest
        // bad checksums, bad addresses, cut frames and line noise.
        frame_no = 0;
        while (frame_items < FRAME_ITEMS) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            if (frame_no == 6 || frame_no == 24)
                hold_off_req = 1'b1;
            if (frame_no == 12 || frame_no == 30)
                drain_fields();
            if ($urandom_range(0, 9) == 0) begin
                noise = $urandom_range(1, 6);
                for (i = 0; i < noise; i++)
                    send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            if (frame_no == 0) begin
                send_frame(FRAME_GOOD, FILL_MAX);
            end else if (frame_no == 1) begin
                send_frame(FRAME_GOOD, FILL_ZERO);
            end else begin
                r = $urandom_range(0, 99);
                kind = (r < 65) ? FRAME_GOOD : (r < 80) ? FRAME_BAD_SUM :
                       (r < 90) ? FRAME_BAD_ADDR : FRAME_CUT;
                send_frame(kind, FILL_RANDOM);
            end
            frame_no++;
        end

        // Close the last frame so the final beat of the run is a status.
        send_frame(FRAME_GOOD, FILL_RANDOM);
        drain_fields();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
